>>> rtl/core/fer_pkg.sv
// Shared types, constants and tables for the fisheye remap coordinate unit.
// Fixed-point formats, CORDIC arctangent table, inverse gain, register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fer_pkg;

	localparam int COORD_BITS    = 14;
	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int NS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int DB  = COORD_BITS + FRAC_BITS;
	localparam int QW  = FRAC_BITS + 1;
	localparam int AW  = FRAC_BITS + 3;
	localparam int VW  = FRAC_BITS + 4;
	localparam int OW  = 16;
	localparam int CFG_W = 14;
	localparam int CROP_W = 12;

	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [VW-1:0] vec_t;

	typedef struct packed {
		logic right;
		logic zero;
		ang_t ang;
		vec_t aux;
	} tag_t;

	typedef enum logic [2:0] {
		REG_LAYOUT,
		REG_ROWS,
		REG_COLS,
		REG_SRC_W,
		REG_SRC_H,
		REG_CROP
	} cfg_reg_t;

	localparam ang_t A_ONE  = AW'(1 << FRAC_BITS);
	localparam ang_t A_HALF = AW'(1 << (FRAC_BITS - 1));
	localparam vec_t V_HALF = VW'(1 << (FRAC_BITS - 1));

	localparam longint ATAN_Q28 [TABLE_LEN] = '{
		67108864, 39616676, 20932363, 10625595, 5333416, 2669308,
		1334980, 667531, 333770, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304, 652,
		326, 163, 81, 41, 20, 10};

	localparam longint KINV_L =
		(64'sh9B74EDA8 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
	localparam vec_t KINV = VW'(KINV_L);

	function automatic ang_t atan_step(input int i);
		return AW'((ATAN_Q28[i] + (64'sd1 <<< (27 - FRAC_BITS))) >>> (28 - FRAC_BITS));
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/fer_div.sv
// Pipelined restoring divider: floor((num << FRAC_BITS) / den), one bit per stage.
// Keeps the low QW quotient bits. Depends on fer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fer_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_i,
	input  logic [fer_pkg::COORD_BITS-1:0]  num,
	input  logic [fer_pkg::COORD_BITS-1:0]  den,
	input  fer_pkg::tag_t                   tag_i,
	output logic                            vld_o,
	output logic [fer_pkg::QW-1:0]          quo,
	output fer_pkg::tag_t                   tag_o
);
	import fer_pkg::*;

	logic [COORD_BITS:0]   rem_in [DB];
	logic [COORD_BITS:0]   rem_nx [DB];
	logic [COORD_BITS-1:0] num_in [DB];
	logic [QW-1:0]         quo_in [DB];
	logic [QW-1:0]         quo_nx [DB];
	tag_t                  tag_in [DB];

	logic [COORD_BITS:0]   rem_s1 [DB];
	logic [COORD_BITS-1:0] num_s1 [DB];
	logic [QW-1:0]         quo_s1 [DB];
	tag_t                  tag_s1 [DB];
	logic [DB-1:0]         vld_s1;

	always_comb begin
		rem_in[0] = '0;
		num_in[0] = num;
		quo_in[0] = '0;
		tag_in[0] = tag_i;
		for (int j = 1; j < DB; j++) begin
			rem_in[j] = rem_s1[j-1];
			num_in[j] = num_s1[j-1];
			quo_in[j] = quo_s1[j-1];
			tag_in[j] = tag_s1[j-1];
		end
		for (int j = 0; j < DB; j++) begin
			logic                b;
			logic [COORD_BITS:0] tr;
			logic                ge;
			b = 1'b0;
			if ((DB - 1 - j) >= FRAC_BITS)
				b = num_in[j][DB - 1 - j - FRAC_BITS];
			tr = {rem_in[j][COORD_BITS-1:0], b};
			ge = (tr >= {1'b0, den});
			rem_nx[j] = ge ? (tr - {1'b0, den}) : tr;
			quo_nx[j] = {quo_in[j][QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
		end else if (en) begin
			vld_s1 <= {vld_s1[DB-2:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DB; j++) begin
				rem_s1[j] <= rem_nx[j];
				num_s1[j] <= num_in[j];
				quo_s1[j] <= quo_nx[j];
				tag_s1[j] <= tag_in[j];
			end
		end
	end

	assign vld_o = vld_s1[DB-1];
	assign quo   = quo_s1[DB-1];
	assign tag_o = tag_s1[DB-1];

endmodule

`default_nettype wire

>>> rtl/core/fer_rot.sv
// CORDIC rotation pipeline: rotates (mag, 0) by angle z in half turns.
// Wrap and quadrant fold stage, NS micro-rotation stages, sign fix stage. Depends on fer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fer_rot (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  fer_pkg::ang_t z,
	input  fer_pkg::vec_t mag,
	input  fer_pkg::tag_t tag_i,
	output logic          vld_o,
	output fer_pkg::vec_t cx,
	output fer_pkg::vec_t sy,
	output fer_pkg::tag_t tag_o
);
	import fer_pkg::*;

	logic signed [FRAC_BITS:0] w;
	ang_t a0;
	logic flip0;

	logic  vld_s1;
	logic  flip_s1;
	ang_t  a_s1;
	vec_t  x_s1;
	tag_t  tag_s1;

	vec_t x_in [NS];
	vec_t y_in [NS];
	ang_t a_in [NS];
	vec_t x_nx [NS];
	vec_t y_nx [NS];
	ang_t a_nx [NS];

	vec_t          x_s2 [NS];
	vec_t          y_s2 [NS];
	ang_t          a_s2 [NS];
	tag_t          tag_s2 [NS];
	logic [NS-1:0] flip_s2;
	logic [NS-1:0] vld_s2;

	logic vld_s3;
	vec_t cx_s3;
	vec_t sy_s3;
	tag_t tag_s3;

	always_comb begin
		w = z[FRAC_BITS:0];
		a0 = AW'(w);
		flip0 = 1'b0;
		if (a0 > A_HALF) begin
			a0 = a0 - A_ONE;
			flip0 = 1'b1;
		end else if (a0 < -A_HALF) begin
			a0 = a0 + A_ONE;
			flip0 = 1'b1;
		end
	end

	always_comb begin
		x_in[0] = x_s1;
		y_in[0] = '0;
		a_in[0] = a_s1;
		for (int j = 1; j < NS; j++) begin
			x_in[j] = x_s2[j-1];
			y_in[j] = y_s2[j-1];
			a_in[j] = a_s2[j-1];
		end
		for (int j = 0; j < NS; j++) begin
			if (a_in[j] >= 0) begin
				x_nx[j] = x_in[j] - (y_in[j] >>> j);
				y_nx[j] = y_in[j] + (x_in[j] >>> j);
				a_nx[j] = a_in[j] - atan_step(j);
			end else begin
				x_nx[j] = x_in[j] + (y_in[j] >>> j);
				y_nx[j] = y_in[j] - (x_in[j] >>> j);
				a_nx[j] = a_in[j] + atan_step(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= '0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= {vld_s2[NS-2:0], vld_s1};
			vld_s3 <= vld_s2[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a0;
			x_s1    <= mag;
			flip_s1 <= flip0;
			tag_s1  <= tag_i;
			flip_s2 <= {flip_s2[NS-2:0], flip_s1};
			tag_s2[0] <= tag_s1;
			for (int j = 0; j < NS; j++) begin
				x_s2[j] <= x_nx[j];
				y_s2[j] <= y_nx[j];
				a_s2[j] <= a_nx[j];
			end
			for (int j = 1; j < NS; j++)
				tag_s2[j] <= tag_s2[j-1];
			cx_s3  <= flip_s2[NS-1] ? -x_s2[NS-1] : x_s2[NS-1];
			sy_s3  <= flip_s2[NS-1] ? -y_s2[NS-1] : y_s2[NS-1];
			tag_s3 <= tag_s2[NS-1];
		end
	end

	assign vld_o = vld_s3;
	assign cx    = cx_s3;
	assign sy    = sy_s3;
	assign tag_o = tag_s3;

endmodule

`default_nettype wire

>>> rtl/core/fer_vec.sv
// CORDIC vectoring pipeline: angle (half turns) and scaled length of (x, y).
// Left half-plane fold stage, then NS micro-rotation stages. Depends on fer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fer_vec (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  fer_pkg::vec_t x,
	input  fer_pkg::vec_t y,
	input  fer_pkg::tag_t tag_i,
	output logic          vld_o,
	output fer_pkg::ang_t ang,
	output fer_pkg::vec_t len,
	output fer_pkg::tag_t tag_o
);
	import fer_pkg::*;

	vec_t x0;
	vec_t y0;
	ang_t z0;

	logic vld_s1;
	vec_t x_s1;
	vec_t y_s1;
	ang_t z_s1;
	tag_t tag_s1;

	vec_t x_in [NS];
	vec_t y_in [NS];
	ang_t z_in [NS];
	vec_t x_nx [NS];
	vec_t y_nx [NS];
	ang_t z_nx [NS];

	vec_t          x_s2 [NS];
	vec_t          y_s2 [NS];
	ang_t          z_s2 [NS];
	tag_t          tag_s2 [NS];
	logic [NS-1:0] vld_s2;

	always_comb begin
		x0 = x;
		y0 = y;
		z0 = '0;
		if (x < 0) begin
			z0 = (y >= 0) ? A_ONE : -A_ONE;
			x0 = -x;
			y0 = -y;
		end
	end

	always_comb begin
		x_in[0] = x_s1;
		y_in[0] = y_s1;
		z_in[0] = z_s1;
		for (int j = 1; j < NS; j++) begin
			x_in[j] = x_s2[j-1];
			y_in[j] = y_s2[j-1];
			z_in[j] = z_s2[j-1];
		end
		for (int j = 0; j < NS; j++) begin
			if (y_in[j] >= 0) begin
				x_nx[j] = x_in[j] + (y_in[j] >>> j);
				y_nx[j] = y_in[j] - (x_in[j] >>> j);
				z_nx[j] = z_in[j] + atan_step(j);
			end else begin
				x_nx[j] = x_in[j] - (y_in[j] >>> j);
				y_nx[j] = y_in[j] + (x_in[j] >>> j);
				z_nx[j] = z_in[j] - atan_step(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= '0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= {vld_s2[NS-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x0;
			y_s1   <= y0;
			z_s1   <= z0;
			tag_s1 <= tag_i;
			tag_s2[0] <= tag_s1;
			for (int j = 0; j < NS; j++) begin
				x_s2[j] <= x_nx[j];
				y_s2[j] <= y_nx[j];
				z_s2[j] <= z_nx[j];
			end
			for (int j = 1; j < NS; j++)
				tag_s2[j] <= tag_s2[j-1];
		end
	end

	assign vld_o = vld_s2[NS-1];
	assign ang   = z_s2[NS-1];
	assign len   = x_s2[NS-1];
	assign tag_o = tag_s2[NS-1];

endmodule

`default_nettype wire

>>> rtl/core/fisheye_equirect_remap_coords_unit.sv
// Fisheye-to-equirectangular remap coordinate unit, top level.
// Channels: in (out_col, out_row), out (src_col, src_row), cfg register writes.
// An input word is taken when in_valid and in_ready are high; a result word leaves
// when out_valid and out_ready are high. Exactly one result per input word, in order.
// Throughput: one word per clock while out_ready stays high.
// Path: the bit-serial divider pipeline, two rotation CORDICs, two vectoring CORDICs,
// and five multiply/round register stages, with 14-bit coordinates, 16 fraction bits
// and 16 CORDIC stages.
// Output stall: a skid register catches the finished word; the pipeline freezes
// (in_ready low) only while that register is full, and it drains when out_ready is high.
// cfg: cfg_ready is always high; write only while the unit is empty.
// Reset (arst_n low) clears valid bits and loads the default registers:
// single lens, 2048x1024 target, 2048x1024 source, no crop.
// Depends on fer_pkg, fer_div, fer_rot, fer_vec.
`timescale 1ns / 1ps
`default_nettype none

module fisheye_equirect_remap_coords_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fer_pkg::COORD_BITS-1:0]    out_col,
	input  logic [fer_pkg::COORD_BITS-1:0]    out_row,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [fer_pkg::OW-1:0]     src_col,
	output logic signed [fer_pkg::OW-1:0]     src_row,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [fer_pkg::CFG_W-1:0]         cfg_data
);
	import fer_pkg::*;

	localparam int PW = VW + 1 + OW;
	localparam logic signed [PW-1:0] P_ONE  = PW'(1 << FRAC_BITS);
	localparam logic signed [PW-1:0] P_HALF = PW'(1 << (FRAC_BITS - 1));

	function automatic vec_t qmul(input vec_t a, input vec_t b);
		logic signed [2*VW-1:0] p;
		p = a * b + V_HALF;
		return VW'(p >>> FRAC_BITS);
	endfunction

	logic                  layout_q;
	logic [COORD_BITS-1:0] rows_q;
	logic [COORD_BITS-1:0] cols_q;
	logic [COORD_BITS-1:0] srcw_q;
	logic [COORD_BITS-1:0] srch_q;
	logic [CROP_W-1:0]     crop_q;

	logic en;
	logic skid_q;
	logic signed [OW-1:0] col_q;
	logic signed [OW-1:0] row_q;

	logic [COORD_BITS-1:0] den_c;
	logic [COORD_BITS-2:0] wh;
	logic signed [OW-1:0]  sx_size;
	logic signed [OW-1:0]  sy_size;
	tag_t                  tag_in;

	logic          vld_du;
	logic [QW-1:0] q_u;
	logic [QW-1:0] q_v;
	tag_t          tag_du;
	logic [QW-1:0] u_eff;
	logic [QW-1:0] v_eff;
	ang_t          z_th;
	ang_t          z_ph;

	logic vld_th;
	vec_t ct, st, cp, sp;
	tag_t tag_th;

	logic vld_s1;
	vec_t vx_s1, vy_s1, vz_s1;
	tag_t tag_s1;
	tag_t tag_v1_in;

	logic vld_v1;
	ang_t ang1;
	vec_t len1;
	tag_t tag_v1;

	logic vld_s2;
	vec_t m_s2;
	tag_t tag_s2;
	tag_t tag_s2_nx;

	logic vld_v2;
	ang_t ang2;
	vec_t len2;
	tag_t tag_v2;

	logic vld_s3;
	vec_t rk_s3;
	tag_t tag_s3;

	logic vld_r2;
	vec_t px, py;
	tag_t tag_r2;

	logic vld_s4;
	logic right_s4;
	logic signed [PW-1:0] qx_s4;
	logic signed [PW-1:0] qy_s4;

	logic signed [PW-1:0] qx, qy, limx, limy, rx, ry;
	logic signed [OW-1:0] col_nx, row_nx;

	logic vld_s5;
	logic signed [OW-1:0] col_s5;
	logic signed [OW-1:0] row_s5;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
			rows_q   <= COORD_BITS'(1024);
			cols_q   <= COORD_BITS'(2048);
			srcw_q   <= COORD_BITS'(2048);
			srch_q   <= COORD_BITS'(1024);
			crop_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LAYOUT: layout_q <= cfg_data[0];
				REG_ROWS:   rows_q   <= cfg_data;
				REG_COLS:   cols_q   <= cfg_data;
				REG_SRC_W:  srcw_q   <= cfg_data;
				REG_SRC_H:  srch_q   <= cfg_data;
				REG_CROP:   crop_q   <= cfg_data[CROP_W-1:0];
				default: ;
			endcase
		end
	end

	// derived geometry; the user must keep it static while words are in flight (the unit does not enforce it)
	always_comb begin
		den_c = layout_q ? (cols_q >> 1) : cols_q;
		wh = srcw_q[COORD_BITS-1:1];
		sx_size = (layout_q ? $signed({3'b000, wh}) : $signed({2'b00, srcw_q}))
			- $signed({3'b000, crop_q, 1'b0});
		sy_size = $signed({2'b00, srch_q}) - $signed({3'b000, crop_q, 1'b0});
		tag_in = '0;
		tag_in.right = layout_q && (den_c != '0) && (out_col >= den_c);
	end

	assign en       = ~skid_q;
	assign in_ready = en;

	fer_div u_div_u (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(in_valid & in_ready),
		.num(out_col), .den(den_c), .tag_i(tag_in),
		.vld_o(vld_du), .quo(q_u), .tag_o(tag_du)
	);

	fer_div u_div_v (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(in_valid & in_ready),
		.num(out_row), .den(rows_q), .tag_i('0),
		.vld_o(), .quo(q_v), .tag_o()
	);

	always_comb begin
		u_eff = layout_q ? {1'b0, q_u[FRAC_BITS-1:0]} : q_u;
		if (den_c == '0)
			u_eff = '0;
		v_eff = (rows_q == '0) ? '0 : q_v;
		z_th = A_ONE - AW'(u_eff);
		z_ph = AW'(v_eff);
	end

	fer_rot u_rot_th (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_du),
		.z(z_th), .mag(KINV), .tag_i(tag_du),
		.vld_o(vld_th), .cx(ct), .sy(st), .tag_o(tag_th)
	);

	fer_rot u_rot_ph (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_du),
		.z(z_ph), .mag(KINV), .tag_i('0),
		.vld_o(), .cx(cp), .sy(sp), .tag_o()
	);

	// unit vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= vld_th;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1  <= qmul(ct, sp);
			vy_s1  <= qmul(st, sp);
			vz_s1  <= cp;
			tag_s1 <= tag_th;
		end
	end

	always_comb begin
		tag_v1_in = tag_s1;
		tag_v1_in.zero = (vx_s1 == '0) && (vz_s1 == '0);
		tag_v1_in.aux = vy_s1;
	end

	fer_vec u_vec_t (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s1),
		.x(vx_s1), .y(-vz_s1), .tag_i(tag_v1_in),
		.vld_o(vld_v1), .ang(ang1), .len(len1), .tag_o(tag_v1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_v1;
	end

	always_comb begin
		tag_s2_nx = tag_v1;
		tag_s2_nx.ang = tag_v1.zero ? '0 : ang1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= tag_v1.zero ? '0 : qmul(len1, KINV);
			tag_s2 <= tag_s2_nx;
		end
	end

	fer_vec u_vec_r (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s2),
		.x(tag_s2.aux), .y(m_s2), .tag_i(tag_s2),
		.vld_o(vld_v2), .ang(ang2), .len(len2), .tag_o(tag_v2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_v2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rk_s3  <= qmul(VW'(ang2), KINV);
			tag_s3 <= tag_v2;
		end
	end

	fer_rot u_rot_p (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s3),
		.z(tag_s3.ang), .mag(rk_s3), .tag_i(tag_s3),
		.vld_o(vld_r2), .cx(px), .sy(py), .tag_o(tag_r2)
	);

	// scale to lens size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_r2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s4    <= (PW'(px) + PW'(V_HALF)) * PW'(sx_size);
			qy_s4    <= (PW'(py) + PW'(V_HALF)) * PW'(sy_size);
			right_s4 <= tag_r2.right;
		end
	end

	// clamp (dual-lens layout only), round half away from zero, offset
	always_comb begin
		limx = $signed(PW'(wh)) <<< FRAC_BITS;
		limy = $signed(PW'(srch_q)) <<< FRAC_BITS;
		qx = qx_s4;
		qy = qy_s4;
		if (layout_q) begin
			if (qx < 0)
				qx = '0;
			if (qx >= limx)
				qx = limx - P_ONE;
			if (qy < 0)
				qy = '0;
			if (qy >= limy)
				qy = limy - P_ONE;
		end
		if (qx >= 0)
			rx = (qx + P_HALF) >>> FRAC_BITS;
		else
			rx = -((-qx + P_HALF) >>> FRAC_BITS);
		if (qy >= 0)
			ry = (qy + P_HALF) >>> FRAC_BITS;
		else
			ry = -((-qy + P_HALF) >>> FRAC_BITS);
		col_nx = OW'(rx) + OW'(crop_q) + (right_s4 ? OW'(wh) : OW'(0));
		row_nx = OW'(ry) + OW'(crop_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (en)
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s5 <= col_nx;
			row_s5 <= row_nx;
		end
	end

	// output skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			skid_q <= 1'b0;
		else if (skid_q)
			skid_q <= ~out_ready;
		else
			skid_q <= vld_s5 & ~out_ready;
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			col_q <= col_s5;
			row_q <= row_s5;
		end
	end

	assign out_valid = skid_q | vld_s5;
	assign src_col   = skid_q ? col_q : col_s5;
	assign src_row   = skid_q ? row_q : row_s5;

endmodule

`default_nettype wire

>>> rtl/core/fer_chk.sv
// Port-level checks for the remap coordinate unit, bound to the top level.
// Watches in_ready, the output handshake and the output skid behavior. Binds into the top level.
`timescale 1ns / 1ps
`default_nettype none

module fer_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] src_col,
	input logic [15:0] src_row
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(src_col) && $stable(src_row))
		else $error("result word changed while stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("input side not reopened after skid drained");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input closed without an output stall");

	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input closed with no word waiting");

endmodule

bind fisheye_equirect_remap_coords_unit fer_chk u_fer_chk (.*);

`default_nettype wire
